FILE: rtl/core/abf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types, register indexes, microcode fields and the control store of
// the alpha-beta-gamma tracking filter.
// ----------------------------------------------------------------------------
package abf_pkg;

	// Wide intermediate arithmetic
	localparam int WIDE_W = 64;
	localparam logic signed [WIDE_W-1:0] WIDE_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HSQ   = 3'd4;

	localparam logic [CFG_DATA_W-1:0] DT_RESET  = 31'd65536;
	localparam logic [CFG_DATA_W-1:0] HSQ_RESET = 31'd32768;

	// Multiplier operand load select
	typedef logic [1:0] ld_sel_t;
	localparam ld_sel_t LD_NONE = 2'd0;
	localparam ld_sel_t LD_VEL  = 2'd1;
	localparam ld_sel_t LD_ACC  = 2'd2;
	localparam ld_sel_t LD_RES  = 2'd3;

	// Multiplier half select
	typedef logic [1:0] mul_op_t;
	localparam mul_op_t MUL_NONE = 2'd0;
	localparam mul_op_t MUL_LO   = 2'd1;
	localparam mul_op_t MUL_HI   = 2'd2;

	// Gain select
	typedef logic [2:0] gain_sel_t;
	localparam gain_sel_t G_DT    = 3'd0;
	localparam gain_sel_t G_HSQ   = 3'd1;
	localparam gain_sel_t G_ALPHA = 3'd2;
	localparam gain_sel_t G_BETA  = 3'd3;
	localparam gain_sel_t G_GAMMA = 3'd4;

	// Adder operation: operands and destination
	typedef logic [2:0] add_op_t;
	localparam add_op_t ADD_NONE   = 3'd0;
	localparam add_op_t ADD_P_POS  = 3'd1;
	localparam add_op_t ADD_P_P    = 3'd2;
	localparam add_op_t ADD_VP_VEL = 3'd3;
	localparam add_op_t ADD_VP_VP  = 3'd4;
	localparam add_op_t ADD_RES    = 3'd5;
	localparam add_op_t ADD_NA     = 3'd6;

	// One control word
	typedef struct packed {
		ld_sel_t   ld;
		mul_op_t   mul;
		gain_sel_t gsel;
		logic      rnd;
		add_op_t   add;
		logic      wb;
	} ucode_t;

	localparam ucode_t UCODE_NOP = '{LD_NONE, MUL_NONE, G_DT, 1'b0, ADD_NONE, 1'b0};

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_LAST = 5'd17;

	// Control store: units overlap, so a product rounds while the next multiplies
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t cw;
		cw = UCODE_NOP;
		case (step)
			5'd0:  begin cw.ld = LD_VEL; end
			5'd1:  begin cw.mul = MUL_LO; cw.gsel = G_DT; end
			5'd2:  begin cw.mul = MUL_HI; cw.gsel = G_DT; cw.ld = LD_ACC; end
			5'd3:  begin cw.rnd = 1'b1; cw.mul = MUL_LO; cw.gsel = G_HSQ; end
			5'd4:  begin cw.add = ADD_P_POS; cw.mul = MUL_HI; cw.gsel = G_HSQ; end
			5'd5:  begin cw.rnd = 1'b1; cw.mul = MUL_LO; cw.gsel = G_DT; end
			5'd6:  begin cw.add = ADD_P_P; cw.mul = MUL_HI; cw.gsel = G_DT; end
			5'd7:  begin cw.rnd = 1'b1; cw.add = ADD_RES; end
			5'd8:  begin cw.add = ADD_VP_VEL; cw.ld = LD_RES; end
			5'd9:  begin cw.mul = MUL_LO; cw.gsel = G_ALPHA; end
			5'd10: begin cw.mul = MUL_HI; cw.gsel = G_ALPHA; end
			5'd11: begin cw.rnd = 1'b1; cw.mul = MUL_LO; cw.gsel = G_BETA; end
			5'd12: begin cw.add = ADD_P_P; cw.mul = MUL_HI; cw.gsel = G_BETA; end
			5'd13: begin cw.rnd = 1'b1; cw.mul = MUL_LO; cw.gsel = G_GAMMA; end
			5'd14: begin cw.add = ADD_VP_VP; cw.mul = MUL_HI; cw.gsel = G_GAMMA; end
			5'd15: begin cw.rnd = 1'b1; end
			5'd16: begin cw.add = ADD_NA; end
			5'd17: begin cw.wb = 1'b1; end
			default: begin cw = UCODE_NOP; end
		endcase
		return cw;
	endfunction

	// Clamp a wide sum to +-WIDE_LIM
	function automatic logic signed [WIDE_W-1:0] clamp_wide(input logic signed [WIDE_W-1:0] x);
		if (x > WIDE_LIM)
			return WIDE_LIM;
		if (x < -WIDE_LIM)
			return -WIDE_LIM;
		return x;
	endfunction

	// Saturate a wide value to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648)
			return 32'sh8000_0000;
		return x[31:0];
	endfunction

endpackage

FILE: rtl/core/alpha_beta_gamma_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_beta_gamma_filter
// Alpha-beta-gamma tracker on signed Q16.16 position samples, run by a small
// microprogram over one shared 32x31 multiplier and one wide clamping adder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, payload measurement) takes one
//   position sample per transaction. Output channel (out_valid / out_stall)
//   returns one transaction per sample: position, velocity, acceleration.
//   in_stall is high while a sample is being worked on.
//   A sample is stepped by the control store through 12 half-products on
//   the single multiplier (two per product, six products), then rounding,
//   the last add and write-back.
//   The result sits in an output register; the next sample is accepted while
//   it waits. If it is still not taken when the next write-back is due, the
//   sequencer holds on that step until the receiver drops out_stall.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
//   used only while the block is idle; unknown indexes are ignored.
//   Reset (arst_n low) clears the estimates, the gains to zero, dt to 1.0 and
//   dt^2/2 to 0.5, and empties the output register.
// ----------------------------------------------------------------------------
module alpha_beta_gamma_filter #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [abf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [abf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            measurement,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            position,
	output logic signed [31:0]            velocity,
	output logic signed [31:0]            acceleration
);
	import abf_pkg::*;

	localparam logic signed [WIDE_W-1:0] DW_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [WIDE_W-1:0] DW_MIN = -DW_MAX - 64'sd1;

	function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [WIDE_W-1:0] x);
		if (x > DW_MAX)
			return DW_MAX[DATA_WIDTH-1:0];
		if (x < DW_MIN)
			return DW_MIN[DATA_WIDTH-1:0];
		return x[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [WIDE_W-1:0] ext_dw(input logic signed [DATA_WIDTH-1:0] x);
		return {{(WIDE_W - DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
	endfunction

	// Configuration registers
	logic [16:0]           alpha_q;
	logic [CFG_DATA_W-1:0] beta_q;
	logic [CFG_DATA_W-1:0] gamma_q;
	logic [CFG_DATA_W-1:0] dt_q;
	logic [CFG_DATA_W-1:0] hsq_q;

	// Filter state
	logic signed [DATA_WIDTH-1:0] pos_est_q;
	logic signed [DATA_WIDTH-1:0] vel_est_q;
	logic signed [DATA_WIDTH-1:0] acc_est_q;

	// Sequencer
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	ucode_t            cw;
	logic              advance;

	// Datapath registers
	logic signed [WIDE_W-1:0] y_q;
	logic [61:0]              mag_q;
	logic                     neg_q;
	logic                     neg_m_q;
	logic [62:0]              pl_q;
	logic [60:0]              ph_q;
	logic signed [WIDE_W-1:0] prod_q;
	logic signed [WIDE_W-1:0] p_q;
	logic signed [WIDE_W-1:0] vp_q;
	logic signed [WIDE_W-1:0] r_q;
	logic signed [WIDE_W-1:0] na_q;

	// Output register
	logic               out_valid_q;
	logic signed [31:0] pos_out_q;
	logic signed [31:0] vel_out_q;
	logic signed [31:0] acc_out_q;

	logic in_take;
	logic out_take;

	assign in_stall  = busy_q;
	assign in_take   = in_valid && !busy_q;
	assign out_take  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign position     = pos_out_q;
	assign velocity     = vel_out_q;
	assign acceleration = acc_out_q;

	// Fetch the control word; hold write-back while the old result waits
	assign cw      = busy_q ? ucode_rom(step_q) : UCODE_NOP;
	assign advance = !(cw.wb && out_valid_q && out_stall);

	// Operand load: magnitude and sign
	logic signed [WIDE_W-1:0] ld_val;
	logic [WIDE_W-1:0]        ld_abs;
	always_comb begin
		case (cw.ld)
			LD_VEL:  ld_val = ext_dw(vel_est_q);
			LD_ACC:  ld_val = ext_dw(acc_est_q);
			LD_RES:  ld_val = r_q;
			default: ld_val = '0;
		endcase
		ld_abs = ld_val[WIDE_W-1] ? WIDE_W'(-ld_val) : WIDE_W'(ld_val);
	end

	// Shared multiplier: one half of the magnitude times one gain
	logic [31:0] mul_a;
	logic [30:0] mul_g;
	logic [62:0] mul_p;
	always_comb begin
		case (cw.gsel)
			G_DT:    mul_g = dt_q;
			G_HSQ:   mul_g = hsq_q;
			G_ALPHA: mul_g = {14'd0, alpha_q};
			G_BETA:  mul_g = beta_q;
			G_GAMMA: mul_g = gamma_q;
			default: mul_g = '0;
		endcase
		mul_a = (cw.mul == MUL_HI) ? {2'd0, mag_q[61:32]} : mag_q[31:0];
	end
	assign mul_p = 63'(mul_a) * 63'(mul_g);

	// Rounding: recombine halves, round to nearest, clamp, restore sign
	logic [WIDE_W-1:0]        rnd_lo;
	logic [WIDE_W-1:0]        rnd_mag;
	logic signed [WIDE_W-1:0] rnd_val;
	always_comb begin
		rnd_lo = ({1'b0, pl_q} + 64'd32768) >> 16;
		if (|ph_q[60:46]) begin
			rnd_mag = WIDE_LIM;
		end else begin
			rnd_mag = {2'd0, ph_q[45:0], 16'd0} + rnd_lo;
			if (rnd_mag > WIDE_LIM)
				rnd_mag = WIDE_LIM;
		end
		rnd_val = neg_m_q ? -$signed(rnd_mag) : $signed(rnd_mag);
	end

	// Wide clamping adder
	logic signed [WIDE_W-1:0] add_a;
	logic signed [WIDE_W-1:0] add_b;
	logic signed [WIDE_W-1:0] add_sum;
	always_comb begin
		case (cw.add)
			ADD_P_POS:  begin add_a = ext_dw(pos_est_q); add_b = prod_q; end
			ADD_P_P:    begin add_a = p_q;               add_b = prod_q; end
			ADD_VP_VEL: begin add_a = ext_dw(vel_est_q); add_b = prod_q; end
			ADD_VP_VP:  begin add_a = vp_q;              add_b = prod_q; end
			ADD_RES:    begin add_a = y_q;               add_b = -p_q;   end
			ADD_NA:     begin add_a = ext_dw(acc_est_q); add_b = prod_q; end
			default:    begin add_a = '0;                add_b = '0;     end
		endcase
		add_sum = clamp_wide(add_a + add_b);
	end

	// New state values at write-back
	logic signed [DATA_WIDTH-1:0] nx_sat;
	logic signed [DATA_WIDTH-1:0] nv_sat;
	logic signed [DATA_WIDTH-1:0] na_sat;
	assign nx_sat = sat_dw(p_q);
	assign nv_sat = sat_dw(vp_q);
	assign na_sat = sat_dw(na_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= '0;
			gamma_q <= '0;
			dt_q    <= DT_RESET;
			hsq_q   <= HSQ_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data[16:0];
				REG_BETA:  beta_q  <= cfg_data;
				REG_GAMMA: gamma_q <= cfg_data;
				REG_DT:    dt_q    <= cfg_data;
				REG_HSQ:   hsq_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Sequencer: step counter, busy flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b0;
			if (in_take) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q && advance) begin
				if (cw.wb) begin
					busy_q      <= 1'b0;
					step_q      <= '0;
					out_valid_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Filter state: update once per transaction at write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_est_q <= '0;
			vel_est_q <= '0;
			acc_est_q <= '0;
		end else if (cw.wb && advance) begin
			pos_est_q <= nx_sat;
			vel_est_q <= nv_sat;
			acc_est_q <= na_sat;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_take)
			y_q <= {{(WIDE_W - 32){measurement[31]}}, measurement};
		if (cw.ld != LD_NONE) begin
			mag_q <= ld_abs[61:0];
			neg_q <= ld_val[WIDE_W-1];
		end
		if (cw.mul == MUL_LO) begin
			pl_q    <= mul_p;
			neg_m_q <= neg_q;
		end
		if (cw.mul == MUL_HI)
			ph_q <= mul_p[60:0];
		if (cw.rnd)
			prod_q <= rnd_val;
		case (cw.add)
			ADD_P_POS, ADD_P_P:    p_q  <= add_sum;
			ADD_VP_VEL, ADD_VP_VP: vp_q <= add_sum;
			ADD_RES:               r_q  <= add_sum;
			ADD_NA:                na_q <= add_sum;
			default:               ;
		endcase
		if (cw.wb && advance) begin
			pos_out_q <= sat32(ext_dw(nx_sat));
			vel_out_q <= sat32(ext_dw(nv_sat));
			acc_out_q <= sat32(ext_dw(na_sat));
		end
	end

	// Checks
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= STEP_LAST))
		else $error("step counter ran past the last control word");

	a_valid_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(busy_q) && ($past(step_q) == STEP_LAST)))
		else $error("result raised outside the write-back step");

	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(busy_q) |-> ($stable(pos_est_q) && $stable(vel_est_q) && $stable(acc_est_q)))
		else $error("estimates changed while no sample was in progress");

endmodule

FILE: test/abg_estimate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abg_estimate_checker
// Tracks register writes and sample transactions of the alpha-beta-gamma
// filter and keeps its own fixed-point copy of the estimates. Each accepted
// sample queues the expected position, velocity and acceleration. Each
// accepted result is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module abg_estimate_checker #(
	parameter int STATE_W = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [abf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic signed [31:0]             measurement,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic signed [31:0]             position,
	input  logic signed [31:0]             velocity,
	input  logic signed [31:0]             acceleration,
	output int                             errors,
	output int                             pending,
	output int                             checked
);
	import abf_pkg::*;

	typedef logic signed [63:0] wide_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
	} estimate_t;

	localparam wide_t       SUM_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] PROD_CEIL = 64'd1 << 46;

	// Shadow registers and estimates
	logic [16:0] gain_alpha;
	logic [30:0] gain_beta;
	logic [30:0] gain_gamma;
	logic [30:0] dt;
	logic [30:0] dt_sq_half;
	wide_t       est_pos;
	wide_t       est_vel;
	wide_t       est_acc;
	estimate_t   estimate_q[$];
	estimate_t   oldest;

	// Wide sum, clamped symmetrically
	function automatic wide_t bounded_add(input wide_t a, input wide_t b);
		wide_t s;
		s = a + b;
		if (s > SUM_LIMIT)
			return SUM_LIMIT;
		if (s < -SUM_LIMIT)
			return -SUM_LIMIT;
		return s;
	endfunction

	// Signed value times unsigned Q16.16 gain, rounded half away from zero
	function automatic wide_t scale_q16(input wide_t a, input logic [30:0] g);
		logic [63:0] mag;
		logic [63:0] g64;
		logic [63:0] hi_prod;
		logic [63:0] lo_prod;
		logic [63:0] res;
		mag = (a < 0) ? -a : a;
		g64 = 64'(g);
		hi_prod = (mag >> 32) * g64;
		lo_prod = (mag & 64'hFFFF_FFFF) * g64;
		if (hi_prod >= PROD_CEIL) begin
			res = SUM_LIMIT;
		end else begin
			res = (hi_prod << 16) + ((lo_prod + 64'd32768) >> 16);
			if (res > SUM_LIMIT)
				res = SUM_LIMIT;
		end
		return (a < 0) ? -wide_t'(res) : wide_t'(res);
	endfunction

	function automatic wide_t saturate(input wide_t x, input int w);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// Predict, form the residual, correct; returns the new estimates
	function automatic estimate_t track_update(input logic signed [31:0] meas);
		wide_t     pred_pos;
		wide_t     pred_vel;
		wide_t     resid;
		estimate_t e;
		pred_pos = bounded_add(est_pos, scale_q16(est_vel, dt));
		pred_pos = bounded_add(pred_pos, scale_q16(est_acc, dt_sq_half));
		pred_vel = bounded_add(est_vel, scale_q16(est_acc, dt));
		resid = bounded_add(wide_t'(meas), -pred_pos);
		est_pos = saturate(bounded_add(pred_pos, scale_q16(resid, 31'(gain_alpha))), STATE_W);
		est_vel = saturate(bounded_add(pred_vel, scale_q16(resid, gain_beta)), STATE_W);
		est_acc = saturate(bounded_add(est_acc, scale_q16(resid, gain_gamma)), STATE_W);
		e.pos = 32'(saturate(est_pos, 32));
		e.vel = 32'(saturate(est_vel, 32));
		e.acc = 32'(saturate(est_acc, 32));
		return e;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s of result %0d is %0d, expected %0d",
				name, checked, got, want));
	endtask

	// Follow register writes, retire results, then queue new samples
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_alpha = '0;
			gain_beta = '0;
			gain_gamma = '0;
			dt = DT_RESET;
			dt_sq_half = HSQ_RESET;
			est_pos = '0;
			est_vel = '0;
			est_acc = '0;
			estimate_q.delete();
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHA: gain_alpha = cfg_data[16:0];
					REG_BETA:  gain_beta = cfg_data;
					REG_GAMMA: gain_gamma = cfg_data;
					REG_DT:    dt = cfg_data;
					REG_HSQ:   dt_sq_half = cfg_data;
					default:   ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (estimate_q.size() == 0) begin
					report_mismatch("result transaction with no sample outstanding");
				end else begin
					oldest = estimate_q.pop_front();
					check_field("position", position, oldest.pos);
					check_field("velocity", velocity, oldest.vel);
					check_field("acceleration", acceleration, oldest.acc);
					checked++;
				end
			end
			if (in_valid && !in_stall)
				estimate_q.push_back(track_update(measurement));
			pending <= estimate_q.size();
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the alpha-beta-gamma filter. A directed opening
// covers saturation extremes, zero step time, gains above one and ignored
// register indexes; then random phases, each with its own register setting,
// feed noisy trajectories mixed with wild samples, with random idling in all but the last.
// ----------------------------------------------------------------------------
module testbench;
	import abf_pkg::*;

	localparam int IDLE_LIMIT     = 2000;
	localparam int HOLD_OFF       = 400;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 150;
	localparam int PRESSURE_PHASE = 3;
	localparam int DRAIN_CYCLES   = 40;
	localparam int ONE            = 65536;
	localparam longint POS_CAP    = 64'sd1 << 30;
	localparam longint VEL_CAP    = 64'sd1 << 22;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic signed [31:0]    measurement = '0;
	logic                  out_stall = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic signed [31:0]    position;
	logic signed [31:0]    velocity;
	logic signed [31:0]    acceleration;
	int                    errors;
	int                    pending;
	int                    checked;

	bit     tx_idle = 1'b1;
	bit     rx_idle = 1'b1;
	int     rx_hold = 0;
	int     sent = 0;
	int     settings = 0;
	int     quiet;
	longint trk_pos = 0;
	longint trk_vel = 0;

	always #2 clk = ~clk;

	alpha_beta_gamma_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .measurement(measurement),
		.out_valid(out_valid), .out_stall(out_stall),
		.position(position), .velocity(velocity), .acceleration(acceleration)
	);

	abg_estimate_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .measurement(measurement),
		.out_valid(out_valid), .out_stall(out_stall),
		.position(position), .velocity(velocity), .acceleration(acceleration),
		.errors(errors), .pending(pending), .checked(checked)
	);

	// Abort when no transaction moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Receiver: long hold-off on request, otherwise random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (rx_idle && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// Offer one sample and hold it until taken, then maybe go quiet
	task automatic push_sample(input logic signed [31:0] v);
		in_valid <= 1'b1;
		measurement <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Program all registers while idle; unused indexes get junk to be ignored
	task automatic load_setting(input logic [30:0] a, input logic [30:0] b,
			input logic [30:0] g, input logic [30:0] d, input logic [30:0] h);
		drain();
		write_reg(REG_ALPHA, a);
		write_reg(REG_BETA, b);
		write_reg(REG_GAMMA, g);
		write_reg(REG_DT, d);
		write_reg(REG_HSQ, h);
		for (int i = int'(REG_HSQ) + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic random_setting(input int kind);
		logic [30:0] a;
		logic [30:0] b;
		logic [30:0] g;
		logic [30:0] d;
		logic [30:0] h;
		case (kind)
			0: begin
				// well-tuned tracker at unit step
				a = 31'($urandom_range(16384, 49152));
				b = 31'($urandom_range(2048, 16384));
				g = 31'($urandom_range(64, 1024));
				d = 31'(ONE);
				h = 31'(ONE / 2);
			end
			1: begin
				d = 31'($urandom_range(0, 2 * ONE));
				h = 31'((64'(d) * 64'(d)) >> 17);
				a = 31'($urandom_range(0, ONE));
				b = 31'($urandom_range(0, ONE));
				g = 31'($urandom_range(0, 8192));
			end
			2: begin
				a = 31'($urandom);
				b = 31'($urandom);
				g = 31'($urandom);
				d = 31'($urandom);
				h = 31'($urandom);
			end
			default: begin
				// gain at or above one, step time either unit or zero
				a = 31'($urandom_range(ONE, 2 * ONE - 1));
				b = 31'($urandom_range(0, 4 * ONE));
				g = 31'($urandom_range(0, ONE));
				d = $urandom_range(0, 1) ? 31'(ONE) : 31'd0;
				h = $urandom_range(0, 1) ? 31'd0 : 31'($urandom_range(0, ONE));
			end
		endcase
		load_setting(a, b, g, d, h);
	endtask

	// Mostly a noisy accelerating trajectory, sometimes anything at all
	function automatic logic signed [31:0] next_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			trk_vel += longint'($urandom_range(0, 4095)) - 2048;
			if (trk_vel > VEL_CAP)
				trk_vel = VEL_CAP;
			else if (trk_vel < -VEL_CAP)
				trk_vel = -VEL_CAP;
			trk_pos += trk_vel;
			if (trk_pos > POS_CAP || trk_pos < -POS_CAP) begin
				trk_vel = -trk_vel;
				trk_pos += 2 * trk_vel;
			end
			return 32'(trk_pos + longint'($urandom_range(0, 8191)) - 4096);
		end
		if (pick < 90)
			return $urandom;
		case ($urandom_range(0, 4))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains are zero: estimates stay put
		push_sample(32'sh7FFF_FFFF);
		push_sample(32'sh8000_0000);

		// every register at its top value, alpha masked down; drive saturation
		load_setting('1, '1, '1, '1, '1);
		push_sample(32'sh7FFF_FFFF);
		push_sample(32'sh8000_0000);
		push_sample(32'sh7FFF_FFFF);
		push_sample(-32'sd1);
		push_sample(32'sd0);
		push_sample(32'sd1);

		// zero step time: only the corrections act
		load_setting(31'(ONE), 31'd16384, 31'd2048, '0, '0);
		push_sample(32'sd1000 <<< 16);
		push_sample(32'sh7FFF_FFFF);
		push_sample(32'sh8000_0000);
		push_sample(32'sh5555_5555);
		push_sample(32'shAAAA_AAAA);
		push_sample(-32'sd1);

		// alpha above one on an accelerating target
		load_setting(31'd98304, 31'd32768, 31'd4096, 31'(ONE), 31'(ONE / 2));
		push_sample(32'sd100 <<< 16);
		push_sample(32'sd101 <<< 16);
		push_sample(32'sd103 <<< 16);
		push_sample(32'sd106 <<< 16);
		push_sample(32'sd110 <<< 16);

		// random phases; the last one runs with no idling on either side
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_setting(ph % 4);
			tx_idle = (ph != RANDOM_PHASES - 1);
			rx_idle = (ph != RANDOM_PHASES - 1);
			trk_pos = longint'($urandom_range(0, 1 << 26)) - (64'sd1 << 25);
			trk_vel = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the output back while samples keep coming, then let it all drain
				if (ph == PRESSURE_PHASE && n == 20) begin
					rx_hold = HOLD_OFF;
					tx_idle = 1'b0;
				end
				if (ph == PRESSURE_PHASE && n == 60) begin
					drain();
					tx_idle = 1'b1;
				end
				push_sample(next_sample());
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d samples over %0d register settings; %0d results compared, %0d errors.",
			sent, settings, checked, errors);
		$display("Covered saturation, zero step time, gain above one, ignored indexes, long hold-off.");
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
